// File: design/adr_pkg.sv
// Package for the divergence right-hand-side unit: data widths, raster limits,
// register indexes and the structs passed between the raster control and the datapath.
// No dependencies.
package adr_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 12;
  localparam int Q_W    = 20;
  localparam int T_W    = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO          = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RHO      = 4'd3;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             first_row;
    logic             frame_end;
  } raster_pos_t;

  typedef struct packed {
    logic [Q_W-1:0] rho;
    logic [Q_W-1:0] inv_rho;
  } coeff_t;

endpackage

// File: design/adr_stream_if.sv
// Valid/ready stream interfaces for the pixel requests and the result requests.
// Depends on adr_pkg for the field widths.
interface adr_in_if;
  import adr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [T_W-1:0]        t_hat;
  logic signed [Q_W-1:0] g_x;
  logic signed [Q_W-1:0] g_y;
  logic signed [Q_W-1:0] dual_x;
  logic signed [Q_W-1:0] dual_y;
  modport source (output valid, t_hat, g_x, g_y, dual_x, dual_y, input ready);
  modport sink (input valid, t_hat, g_x, g_y, dual_x, dual_y, output ready);
endinterface

interface adr_out_if;
  import adr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] rhs_value;
  logic                  saturated;
  logic                  last_of_frame;
  modport source (output valid, rhs_value, saturated, last_of_frame, input ready);
  modport sink (input valid, rhs_value, saturated, last_of_frame, output ready);
endinterface

// File: design/adr_line_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module adr_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 20,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/adr_raster_ctrl.sv
// Configuration registers and raster column/row counters.
// Depends on adr_pkg for widths, register indexes and the position struct.
module adr_raster_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [adr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          advance,
  output adr_pkg::raster_pos_t          pos,
  output adr_pkg::coeff_t               coeff
);
  import adr_pkg::*;

  localparam int CNT_W = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
  localparam int RCNT_W = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [Q_W-1:0]    rho_r, inv_rho_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  w_eff;
  logic [RCNT_W-1:0] h_eff;
  logic              last_col, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= SIZE_W'(MAX_WIDTH);
      height_r  <= SIZE_W'(MAX_HEIGHT);
      rho_r     <= Q_W'(4096);
      inv_rho_r <= Q_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r   <= cfg_wdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r  <= cfg_wdata[SIZE_W-1:0];
        REG_RHO:          rho_r     <= cfg_wdata[Q_W-1:0];
        REG_INV_RHO:      inv_rho_r <= cfg_wdata[Q_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A size of zero acts as one, a size above the maximum acts as the maximum.
  always_comb begin
    if (width_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (CNT_W'(width_r) > CNT_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = RCNT_W'(1);
    end else if (RCNT_W'(height_r) > RCNT_W'(MAX_HEIGHT)) begin
      h_eff = RCNT_W'(MAX_HEIGHT);
    end else begin
      h_eff = RCNT_W'(height_r);
    end
  end

  // A counter at or past the end acts as the last position, so a size lowered
  // in mid-frame still wraps cleanly.
  assign last_col = CNT_W'(col_r) >= (w_eff - CNT_W'(1));
  assign last_row = RCNT_W'(row_r) >= (h_eff - RCNT_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.col       = col_r;
  assign pos.first_col = (col_r == '0);
  assign pos.first_row = (row_r == '0);
  assign pos.frame_end = last_col && last_row;
  assign coeff.rho     = rho_r;
  assign coeff.inv_rho = inv_rho_r;

endmodule

// File: design/admm_divergence_rhs_unit.sv
// Divergence right-hand-side unit: rhs = 2*t_hat - rho*div(b), signed Q8.12, saturated.
// The four-state sequencer takes a new request only when idle, so one pixel is in flight at a time;
// a stalled result register holds it in its output state.
// Reset (synchronous, rst_n low): raster position, left neighbor, sizes and rho registers
// return to their defaults and the result register empties; the line store is not cleared.
module admm_divergence_rhs_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  adr_in_if.sink                        in_pix,
  adr_out_if.source                     out_rhs,
  input  logic                          cfg_we,
  input  logic [adr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import adr_pkg::*;

  // Sequencer codes. One pixel at a time walks through these states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a pixel request
  localparam logic [1:0] ST_DIV  = 2'd1;  // line store data back, form b and divergence
  localparam logic [1:0] ST_MUL  = 2'd2;  // rho times divergence
  localparam logic [1:0] ST_OUT  = 2'd3;  // final sum, hand to the result register

  localparam int PB_W  = 2 * Q_W + 1;     // dual * inv_rho product
  localparam int DIV_W = Q_W + 2;         // exact divergence
  localparam int PR_W  = DIV_W + Q_W + 1; // rho * divergence product
  localparam int WIDE_W = 32;             // common width for saturation

  localparam logic signed [WIDE_W-1:0] Q_MAX = WIDE_W'(524287);
  localparam logic signed [WIDE_W-1:0] Q_MIN = -WIDE_W'(524288);

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[Q_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic clamps(input logic signed [WIDE_W-1:0] v);
    return (v > Q_MAX) || (v < Q_MIN);
  endfunction

  logic [1:0]            state_r, state_nxt;
  logic                  accept;
  logic                  out_load;
  raster_pos_t           pos;
  coeff_t                coeff;

  // Stage registers after acceptance.
  logic signed [PB_W-1:0] prod_x_r, prod_y_r;
  logic signed [Q_W-1:0]  gx_r, gy_r;
  logic [T_W-1:0]         t_hat_r;
  logic [COL_W-1:0]       col_r;
  logic                   first_col_r, first_row_r, frame_end_r;

  // Divergence stage.
  logic signed [Q_W-1:0]    left_bx_r;
  logic signed [Q_W-1:0]    above_by;
  logic signed [DIV_W-1:0]  div_r;
  logic                     sat_b_r;
  logic signed [PR_W-1:0]   prod_r;

  // Result register.
  logic                  out_valid_r;
  logic signed [Q_W-1:0] rhs_r;
  logic                  sat_r;
  logic                  last_r;

  // Combinational terms of the divergence and final stages.
  logic signed [PB_W-1:0]   rnd_x, rnd_y;
  logic signed [WIDE_W-1:0] bx_wide, by_wide;
  logic signed [Q_W-1:0]    bx, by;
  logic signed [Q_W:0]      dx, dy;
  logic signed [PR_W-1:0]   rnd_r;
  logic signed [WIDE_W-1:0] rhs_wide;

  assign accept = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (state_r == ST_IDLE);

  adr_raster_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .pos       (pos),
    .coeff     (coeff)
  );

  // The line store holds by of the row above. It is read when a pixel is
  // accepted and written back with the new by in the next cycle, so a single
  // pixel in flight never overlaps its own read and write.
  adr_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (Q_W)
  ) u_line (
    .clk   (clk),
    .we    (state_r == ST_DIV),
    .waddr (col_r),
    .wdata (by),
    .re    (accept),
    .raddr (pos.col),
    .rdata (above_by)
  );

  // Acceptance: capture the raster flags and form the dual products at once.
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x_r    <= PB_W'(in_pix.dual_x) * $signed({1'b0, coeff.inv_rho});
      prod_y_r    <= PB_W'(in_pix.dual_y) * $signed({1'b0, coeff.inv_rho});
      gx_r        <= in_pix.g_x;
      gy_r        <= in_pix.g_y;
      t_hat_r     <= in_pix.t_hat;
      col_r       <= pos.col;
      first_col_r <= pos.first_col;
      first_row_r <= pos.first_row;
      frame_end_r <= pos.frame_end;
    end
  end

  // Rounding of a Q.24 product back to Q.12 is half toward plus infinity,
  // which is an add of half an LSB and an arithmetic shift.
  always_comb begin
    rnd_x   = (prod_x_r + PB_W'(2048)) >>> 12;
    rnd_y   = (prod_y_r + PB_W'(2048)) >>> 12;
    bx_wide = WIDE_W'(gx_r) + WIDE_W'($signed(rnd_x[PB_W-13:0]));
    by_wide = WIDE_W'(gy_r) + WIDE_W'($signed(rnd_y[PB_W-13:0]));
    bx      = sat_q(bx_wide);
    by      = sat_q(by_wide);
    // Neighbors outside the image count as zero.
    dx = (Q_W + 1)'(bx) - (first_col_r ? '0 : (Q_W + 1)'(left_bx_r));
    dy = (Q_W + 1)'(by) - (first_row_r ? '0 : (Q_W + 1)'(above_by));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bx_r <= '0;
    end else if (state_r == ST_DIV) begin
      left_bx_r <= bx;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      div_r   <= DIV_W'(dx) + DIV_W'(dy);
      sat_b_r <= clamps(bx_wide) || clamps(by_wide);
    end
    if (state_r == ST_MUL) begin
      prod_r <= PR_W'($signed({1'b0, coeff.rho})) * PR_W'(div_r);
    end
  end

  // Final stage: 2*t_hat less the scaled divergence, then saturation.
  always_comb begin
    rnd_r    = (prod_r + PR_W'(2048)) >>> 12;
    rhs_wide = WIDE_W'({t_hat_r, 1'b0}) - WIDE_W'($signed(rnd_r[PR_W-13:0]));
  end

  // The result register takes a new result whenever it is empty or being
  // drained in the same cycle; otherwise the sequencer holds in its last state.
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_rhs.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rhs.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rhs_r  <= sat_q(rhs_wide);
      sat_r  <= sat_b_r || clamps(rhs_wide);
      last_r <= frame_end_r;
    end
  end

  assign out_rhs.valid         = out_valid_r;
  assign out_rhs.rhs_value     = rhs_r;
  assign out_rhs.saturated     = sat_r;
  assign out_rhs.last_of_frame = last_r;

endmodule

// File: design/adr_checker.sv
// Port-level checker for the divergence right-hand-side unit, bound to the top level.
// Depends on adr_pkg for the payload width.
module adr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [adr_pkg::Q_W-1:0]    out_rhs_value,
  input logic                       out_saturated,
  input logic                       out_last
);
  import adr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_rhs_value) && $stable(out_saturated)
                                && $stable(out_last))
    else $error("result payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("pixel request taken while a pixel is still in flight");

  a_reset_state: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("unit not idle after reset");

endmodule

bind admm_divergence_rhs_unit adr_checker u_adr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_pix.valid),
  .in_ready      (in_pix.ready),
  .out_valid     (out_rhs.valid),
  .out_ready     (out_rhs.ready),
  .out_rhs_value (out_rhs.rhs_value),
  .out_saturated (out_rhs.saturated),
  .out_last      (out_rhs.last_of_frame)
);

// File: tb/sv/tb_top.sv
// Self-checking bench for admm_divergence_rhs_unit: random pixel frames go in, rhs requests are
// checked field by field against an in-bench predictor of the divergence stencil.
// Depends on adr_pkg, the adr_in_if / adr_out_if stream interfaces and the unit itself.
module tb_top;
  import adr_pkg::*;

  // Planned pixel count for the whole run, and the share at the end that runs with no idling.
  localparam int PIXEL_TARGET  = 2000;
  localparam int CALM_TAIL     = 200;
  // Idle cycles to wait after the unit drains before touching registers.
  localparam int SETTLE_CYCLES = 8;
  // Watchdog bound on the run; it lies several times over the worst case plus phase overhead.
  localparam int CYCLE_LIMIT   = 250000;
  localparam int PRINT_LIMIT   = 30;

  localparam logic signed [Q_W-1:0] Q_TOP    = 20'sh7FFFF;
  localparam logic signed [Q_W-1:0] Q_BOTTOM = 20'sh80000;
  // Any index past the four real registers must be dropped by the unit.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

  typedef struct {
    logic [T_W-1:0]        t_hat;
    logic signed [Q_W-1:0] g_x;
    logic signed [Q_W-1:0] g_y;
    logic signed [Q_W-1:0] dual_x;
    logic signed [Q_W-1:0] dual_y;
  } pixel_t;

  typedef struct {
    logic signed [Q_W-1:0] rhs_value;
    logic                  saturated;
    logic                  last_of_frame;
  } rhs_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  adr_in_if  pix_if ();
  adr_out_if rhs_if ();

  admm_divergence_rhs_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_rhs   (rhs_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Pixels waiting to be driven, and rhs results predicted but not yet seen.
  pixel_t      pending_pix[$];
  rhs_result_t rhs_expected[$];

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned planned_pixels  = 0;
  bit          pix_taken       = 0;
  bit          idle_on         = 1;
  bit          calm_tail       = 0;
  int unsigned pix_gap         = 0;
  int unsigned rhs_gap         = 0;

  // Shadow copy of the configuration registers, at their reset values.
  logic [SIZE_W-1:0] width_reg   = 12'd2048;
  logic [SIZE_W-1:0] height_reg  = 12'd2048;
  logic [Q_W-1:0]    rho_reg     = 20'd4096;
  logic [Q_W-1:0]    inv_rho_reg = 20'd4096;

  // Predictor state: raster position, the b_x of the pixel to the left and the line of b_y
  // values from the row above.
  int unsigned           col_pos = 0;
  int unsigned           row_pos = 0;
  longint                left_bx = 0;
  logic signed [Q_W-1:0] above_by [MAX_WIDTH];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------------------

  // A size of zero behaves as one and anything above the maximum behaves as the maximum.
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Drop 12 fractional bits, rounding halves toward plus infinity (the shift floors).
  function automatic longint round_q12(longint p);
    return (p + 2048) >>> 12;
  endfunction

  function automatic longint clamp_q(longint v, inout bit hit);
    if (v > longint'(Q_TOP)) begin
      hit = 1'b1;
      return longint'(Q_TOP);
    end
    if (v < longint'(Q_BOTTOM)) begin
      hit = 1'b1;
      return longint'(Q_BOTTOM);
    end
    return v;
  endfunction

  // Works out the rhs request for one accepted pixel and advances the raster state.
  function automatic rhs_result_t predict_rhs(pixel_t p);
    rhs_result_t r;
    bit          hit;
    int unsigned w;
    int unsigned h;
    bit          last_c;
    bit          last_r;
    int unsigned col;
    longint      bx;
    longint      by;
    longint      div;
    longint      acc;
    hit    = 1'b0;
    w      = eff_size(width_reg, MAX_WIDTH);
    h      = eff_size(height_reg, MAX_HEIGHT);
    // A position at or past the end (sizes lowered mid-frame) acts as the last one.
    last_c = col_pos >= w - 1;
    last_r = row_pos >= h - 1;
    col    = col_pos % MAX_WIDTH;
    bx  = clamp_q(longint'(p.g_x) + round_q12(longint'(p.dual_x) * longint'(inv_rho_reg)), hit);
    by  = clamp_q(longint'(p.g_y) + round_q12(longint'(p.dual_y) * longint'(inv_rho_reg)), hit);
    // Neighbors outside the image count as zero.
    div = bx + by;
    if (col_pos > 0) div -= left_bx;
    if (row_pos > 0) div -= longint'(above_by[col]);
    acc = 2 * longint'(p.t_hat) - round_q12(longint'(rho_reg) * div);
    r.rhs_value     = clamp_q(acc, hit);
    r.saturated     = hit;
    r.last_of_frame = last_c && last_r;
    left_bx      = bx;
    above_by[col] = by;
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  // Pixels still needed to reach the end of the current frame with the present sizes.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned cols_left;
    int unsigned rows_after;
    w          = eff_size(width_reg, MAX_WIDTH);
    h          = eff_size(height_reg, MAX_HEIGHT);
    cols_left  = (col_pos >= w - 1) ? 1 : w - col_pos;
    rows_after = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
    return cols_left + rows_after * w;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic pixel_t make_pix(int t, int gx, int gy, int dx, int dy);
    pixel_t p;
    p.t_hat  = t;
    p.g_x    = gx;
    p.g_y    = gy;
    p.dual_x = dx;
    p.dual_y = dy;
    return p;
  endfunction

  // Mix of extremes, small values near the interesting range and full-width noise.
  function automatic logic signed [Q_W-1:0] rand_q();
    case ($urandom_range(0, 7))
      0: return Q_TOP;
      1: return Q_BOTTOM;
      2: return '0;
      3: return '1;
      4, 5: return $urandom_range(0, 32767) - 16384;
      default: return $urandom;
    endcase
  endfunction

  function automatic pixel_t rand_pix();
    pixel_t p;
    case ($urandom_range(0, 5))
      0: p.t_hat = 0;
      1: p.t_hat = 4096;
      2: p.t_hat = 4095;
      default: p.t_hat = $urandom_range(0, 4096);
    endcase
    p.g_x    = rand_q();
    p.g_y    = rand_q();
    p.dual_x = rand_q();
    p.dual_y = rand_q();
    return p;
  endfunction

  function automatic logic [Q_W-1:0] rand_coeff();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 20'd4096;
      3, 4: return $urandom_range(1, 8192);
      default: return $urandom;
    endcase
  endfunction

  // Mostly small frames so that many frame boundaries occur; zero exercises the size floor.
  function automatic logic [SIZE_W-1:0] rand_size(int unsigned top);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      9: return $urandom_range(2, top);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  task automatic queue_random(int unsigned n);
    repeat (n) pending_pix.push_back(rand_pix());
    planned_pixels += n;
  endtask

  // Holds the sender until every predicted request has come back and the unit has settled.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pix.size() != 0 || pix_if.valid || rhs_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------------------------------
  // Pixel driver: changes inputs on the falling edge. A request that was offered but not
  // taken is held unchanged; otherwise the next pixel goes out or a short idle burst starts.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else if (!(pix_if.valid && !pix_taken)) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pix_if.valid <= 1'b0;
      end else if (pending_pix.size() != 0) begin
        if (idle_on && !calm_tail && $urandom_range(0, 3) == 0) begin
          pix_gap = $urandom_range(0, 3);
          pix_if.valid <= 1'b0;
        end else begin
          pix_if.valid  <= 1'b1;
          pix_if.t_hat  <= pending_pix[0].t_hat;
          pix_if.g_x    <= pending_pix[0].g_x;
          pix_if.g_y    <= pending_pix[0].g_y;
          pix_if.dual_x <= pending_pix[0].dual_x;
          pix_if.dual_y <= pending_pix[0].dual_y;
          void'(pending_pix.pop_front());
        end
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result-side back pressure: random stall bursts while idling is on and the calm tail has not begun.
  always @(negedge clk) begin
    if (rhs_gap > 0) begin
      rhs_gap--;
      rhs_if.ready <= 1'b0;
    end else if (idle_on && !calm_tail && $urandom_range(0, 3) == 0) begin
      rhs_gap = $urandom_range(0, 3);
      rhs_if.ready <= 1'b0;
    end else begin
      rhs_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: on each rising edge it tracks register writes, predicts every accepted pixel
  // and checks every accepted rhs request against the oldest prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    rhs_result_t want;
    cycle_count++;
    pix_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg   = cfg_wdata[SIZE_W-1:0];
          REG_IMAGE_HEIGHT: height_reg  = cfg_wdata[SIZE_W-1:0];
          REG_RHO:          rho_reg     = cfg_wdata[Q_W-1:0];
          REG_INV_RHO:      inv_rho_reg = cfg_wdata[Q_W-1:0];
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        pix_taken = 1'b1;
        rhs_expected.push_back(predict_rhs(make_pix(pix_if.t_hat, pix_if.g_x, pix_if.g_y,
                                                    pix_if.dual_x, pix_if.dual_y)));
      end
      if (rhs_if.valid && rhs_if.ready) begin
        if (rhs_expected.size() == 0) begin
          report_mismatch($sformatf("rhs request with nothing expected (rhs_value %0d)",
                                    rhs_if.rhs_value));
        end else begin
          want = rhs_expected.pop_front();
          if (rhs_if.rhs_value !== want.rhs_value)
            report_mismatch($sformatf("rhs_value got %0d want %0d",
                                      rhs_if.rhs_value, want.rhs_value));
          if (rhs_if.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      rhs_if.saturated, want.saturated));
          if (rhs_if.last_of_frame !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame got %b want %b",
                                      rhs_if.last_of_frame, want.last_of_frame));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("admm_divergence_rhs_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned cur_w;
    int unsigned cur_h;
    foreach (above_by[i]) above_by[i] = '0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    pix_if.valid  = 1'b0;
    pix_if.t_hat  = '0;
    pix_if.g_x    = '0;
    pix_if.g_y    = '0;
    pix_if.dual_x = '0;
    pix_if.dual_y = '0;
    rhs_if.ready  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The reset size is a full 2048x2048 frame, so the sizes are written before
    // the first pixel; every later register write happens with the unit drained.
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_RHO, 4096);
    write_reg(REG_INV_RHO, 4096);
    end_writes();
    // A 3x3 frame: field extremes, b_x and b_y clamping both ways, edge neighbors, rounding.
    pending_pix.push_back(make_pix(0, 0, 0, 0, 0));
    pending_pix.push_back(make_pix(4096, Q_TOP, 0, Q_TOP, 0));
    pending_pix.push_back(make_pix(4095, Q_BOTTOM, 12345, Q_BOTTOM, -77));
    pending_pix.push_back(make_pix(1, 0, Q_TOP, 0, Q_TOP));
    pending_pix.push_back(make_pix(2048, -1, Q_BOTTOM, -1, Q_BOTTOM));
    pending_pix.push_back(make_pix(4096, 1, -1, 1, -1));
    pending_pix.push_back(make_pix(0, 4096, -4096, 2048, -2048));
    pending_pix.push_back(rand_pix());
    pending_pix.push_back(rand_pix());
    planned_pixels += 9;
    wait_drained();

    // Zero sizes act as a 1x1 frame, so every pixel ends a frame. The largest rho drives the
    // result into clamping in both directions, and an inverse of one half hits the rounding
    // tie. A write to an index past the register file must change nothing.
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_RHO, 20'hFFFFF);
    write_reg(REG_INV_RHO, 2048);
    write_reg(REG_SPARE, 20'h00001);
    end_writes();
    pending_pix.push_back(make_pix(4096, Q_TOP, Q_TOP, 0, 0));
    pending_pix.push_back(make_pix(0, Q_BOTTOM, Q_BOTTOM, 1, -1));
    pending_pix.push_back(make_pix(4096, 0, 0, 3, -3));
    planned_pixels += 3;
    wait_drained();

    // Oversize registers act as the maximum. Start a frame, then lower the width below the
    // current column so the counter is past the end and must wrap, then do the same with
    // the height to close the frame early.
    write_reg(REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
    write_reg(REG_RHO, 0);
    write_reg(REG_INV_RHO, 20'hFFFFF);
    end_writes();
    queue_random(5);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 3);
    end_writes();
    queue_random(4);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, 2);
    end_writes();
    queue_random(pixels_to_frame_end());

    // Random part: each phase sets new registers with the unit drained and then sends whole
    // frames, so a row-above entry is always written before it is read. Some phases stop
    // mid-frame, lower the sizes and finish the frame under the new geometry.
    while (planned_pixels < PIXEL_TARGET) begin
      wait_drained();
      calm_tail = planned_pixels + CALM_TAIL >= PIXEL_TARGET;
      idle_on   = calm_tail ? 1'b0 : ($urandom_range(0, 4) != 0);
      write_reg(REG_IMAGE_WIDTH, rand_size(40));
      write_reg(REG_IMAGE_HEIGHT, rand_size(12));
      if ($urandom_range(0, 3) != 0) write_reg(REG_RHO, rand_coeff());
      if ($urandom_range(0, 3) != 0) write_reg(REG_INV_RHO, rand_coeff());
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
      end_writes();
      n = pixels_to_frame_end();
      if (n > 1 && !calm_tail && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, n - 1);
        queue_random(k);
        wait_drained();
        cur_w = eff_size(width_reg, MAX_WIDTH);
        cur_h = eff_size(height_reg, MAX_HEIGHT);
        // Only lowering is safe here: a wider row would read line entries never written.
        if ($urandom_range(0, 1) == 0) write_reg(REG_IMAGE_WIDTH, $urandom_range(0, cur_w));
        if ($urandom_range(0, 1) == 0) write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, cur_h));
        if ($urandom_range(0, 2) == 0) write_reg(REG_RHO, rand_coeff());
        end_writes();
        queue_random(pixels_to_frame_end());
      end else begin
        queue_random(n * $urandom_range(1, 3));
      end
    end

    // Everything has been queued; wait for the last requests and watch for strays.
    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("admm_divergence_rhs_unit test passed");
    end else begin
      $display("admm_divergence_rhs_unit test failed");
    end
    $finish;
  end

endmodule
